FILE: design/fta_pkg.sv
// Shared widths and types for the fixed-timestep accumulator.
package fta_pkg;

    localparam int unsigned TIME_W  = 32;   // microsecond quantities
    localparam int unsigned FRAC_W  = 16;   // Q0.16 blend fraction
    localparam int unsigned COUNT_W = 8;    // substep count / limit
    localparam int unsigned ITER_W  = 6;    // divider iteration counter

    // Serial divider iterations: integer quotient bits, then fraction bits.
    localparam int unsigned DIV_STEPS = TIME_W + FRAC_W;

    // shift-add multiplier bit counter
    localparam int unsigned MUL_CNT_W = $clog2(COUNT_W + 1);

    localparam logic [TIME_W-1:0]  STEP_RESET    = 32'd16667;
    localparam logic [TIME_W-1:0]  FRAME_RESET   = 32'd100000;
    localparam logic [COUNT_W-1:0] SUBSTEP_RESET = 8'd8;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSTEP_LIMIT = 2'd2;

    localparam int unsigned OUT_W = 64;     // result word, padded to bytes

    typedef struct packed {
        logic [TIME_W-1:0] quotient;
        logic [TIME_W-1:0] remainder;
        logic [FRAC_W-1:0] frac;
    } div_result_t;

endpackage

FILE: design/fta_div.sv
// Bit-serial restoring divider: 32 quotient bits, then 16 fraction bits of remainder/divisor.
module fta_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [fta_pkg::TIME_W-1:0]         dividend,
    input  logic [fta_pkg::TIME_W-1:0]         divisor,   // held stable while busy
    output logic                               done,
    output fta_pkg::div_result_t               result
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [fta_pkg::ITER_W-1:0]        iter_reg, iter_next;
    logic [fta_pkg::TIME_W-1:0]        rem_reg, rem_next;
    logic [fta_pkg::TIME_W-1:0]        dvd_reg, dvd_next;
    logic [fta_pkg::TIME_W-1:0]        quo_reg, quo_next;
    logic [fta_pkg::FRAC_W-1:0]        frac_reg, frac_next;

    logic                              int_phase;
    logic [fta_pkg::TIME_W:0]          shifted;
    logic [fta_pkg::TIME_W+1:0]        diff;
    logic                              fits;

    // iterations 0..31 consume dividend bits, 32..47 feed zeros for the fraction
    assign int_phase = ~iter_reg[fta_pkg::ITER_W-1];
    assign shifted   = {rem_reg, int_phase & dvd_reg[fta_pkg::TIME_W-1]};
    assign diff      = {1'b0, shifted} - {2'b00, divisor};
    assign fits      = ~diff[fta_pkg::TIME_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        frac_next = frac_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = '0;
            rem_next  = '0;
            dvd_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? diff[fta_pkg::TIME_W-1:0] : shifted[fta_pkg::TIME_W-1:0];
            if (int_phase) begin
                dvd_next = {dvd_reg[fta_pkg::TIME_W-2:0], 1'b0};
                quo_next = {quo_reg[fta_pkg::TIME_W-2:0], fits};
            end else begin
                frac_next = {frac_reg[fta_pkg::FRAC_W-2:0], fits};
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == fta_pkg::ITER_W'(fta_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        iter_reg <= iter_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        frac_reg <= frac_next;
    end

    // remainder after the integer phase is overwritten by the fraction phase
    // in rem_reg, so keep a copy of it
    logic [fta_pkg::TIME_W-1:0] int_rem_reg, int_rem_next;
    always_comb begin
        int_rem_next = int_rem_reg;
        if (busy_reg && iter_reg == fta_pkg::ITER_W'(fta_pkg::TIME_W - 1)) begin
            int_rem_next = rem_next;
        end
    end
    always_ff @(posedge aclk) begin
        int_rem_reg <= int_rem_next;
    end

    assign done             = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = int_rem_reg;
    assign result.frac      = frac_reg;

endmodule

FILE: design/fixed_timestep_accumulator.sv
// Fixed-timestep accumulator: banks frame time, reports substeps, blend alpha, simulated time.
//
// Each input request is one frame's elapsed time in microseconds; it is added to the time
// bank, clamped to frame_limit, and split into whole steps of step_length (capped at
// substep_limit, whole steps beyond the cap dropped), the leftover Q0.16 fraction and the
// simulated time. One request at a time: after a request is taken, the bit-serial divider
// produces 32 quotient and 16 fraction bits, its result is handed over, a serial shift-add
// forms count times step and the output register is loaded; only then does the block return
// to idle and take the next request. With step_length zero the divider and multiplier are
// skipped and the output register is loaded straight after the request. A result still
// unaccepted in the output register holds the next one back until it is accepted. A finished
// result waits in the output register while the next request is already taken. Configuration
// writes land immediately and must only be made while the block is idle.
module fixed_timestep_accumulator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fta_pkg::TIME_W-1:0]          s_tdata,    // [31:0] elapsed
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] substep_count, [8] time_dropped, [24:9] blend_alpha,
    // [56:25] simulated_time, [63:57] zero
    output logic [fta_pkg::OUT_W-1:0]           m_tdata,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [fta_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fta_pkg::TIME_W-1:0]          cfg_wr_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic [fta_pkg::TIME_W-1:0]          step_reg, step_next;
    logic [fta_pkg::TIME_W-1:0]          frame_reg, frame_next;
    logic [fta_pkg::COUNT_W-1:0]         limit_reg, limit_next;
    logic [fta_pkg::TIME_W-1:0]          bank_reg, bank_next;

    logic [fta_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic                                dropped_reg, dropped_next;
    logic [fta_pkg::FRAC_W-1:0]          alpha_reg, alpha_next;
    logic [fta_pkg::TIME_W-1:0]          prod_reg, prod_next;
    logic [fta_pkg::COUNT_W-1:0]         mbits_reg, mbits_next;
    logic [fta_pkg::MUL_CNT_W-1:0]       mcnt_reg, mcnt_next;

    logic                                out_valid_reg, out_valid_next;
    logic [fta_pkg::OUT_W-1:0]           out_data_reg, out_data_next;

    logic                                in_req;
    logic [fta_pkg::TIME_W:0]            sum;
    logic [fta_pkg::TIME_W-1:0]          clamped;
    logic                                div_start;
    logic                                div_done;
    fta_pkg::div_result_t                div_res;
    logic                                over_cap;

    assign s_tready = state_reg == ST_IDLE;
    assign in_req   = s_tvalid && s_tready;

    assign sum     = {1'b0, bank_reg} + {1'b0, s_tdata};
    assign clamped = (sum < {1'b0, frame_reg}) ? sum[fta_pkg::TIME_W-1:0] : frame_reg;

    assign div_start = in_req && (step_reg != '0);

    fta_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (clamped),
        .divisor  (step_reg),
        .done     (div_done),
        .result   (div_res)
    );

    assign over_cap =
        (div_res.quotient[fta_pkg::TIME_W-1:fta_pkg::COUNT_W] != '0) ||
        (div_res.quotient[fta_pkg::COUNT_W-1:0] > limit_reg);

    // configuration writes
    always_comb begin
        step_next  = step_reg;
        frame_next = frame_reg;
        limit_next = limit_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                fta_pkg::CFG_STEP_LENGTH:   step_next  = cfg_wr_data;
                fta_pkg::CFG_FRAME_LIMIT:   frame_next = cfg_wr_data;
                fta_pkg::CFG_SUBSTEP_LIMIT: limit_next = cfg_wr_data[fta_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        alpha_next     = alpha_reg;
        prod_next      = prod_reg;
        mbits_next     = mbits_reg;
        mcnt_next      = mcnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_req) begin
                    bank_next = clamped;
                    if (step_reg == '0) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        alpha_next   = '0;
                        prod_next    = '0;
                        state_next   = ST_OUT;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    // leftover is bank mod step whether or not the cap cut in
                    bank_next    = div_res.remainder;
                    alpha_next   = div_res.frac;
                    dropped_next = over_cap;
                    count_next   = over_cap ? limit_reg
                                            : div_res.quotient[fta_pkg::COUNT_W-1:0];
                    mbits_next   = count_next;
                    prod_next    = '0;
                    mcnt_next    = fta_pkg::MUL_CNT_W'(fta_pkg::COUNT_W);
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                // MSB-first shift-add; partial products never exceed the final one
                prod_next  = {prod_reg[fta_pkg::TIME_W-2:0], 1'b0}
                           + (mbits_reg[fta_pkg::COUNT_W-1] ? step_reg : '0);
                mbits_next = {mbits_reg[fta_pkg::COUNT_W-2:0], 1'b0};
                mcnt_next  = mcnt_reg - 1'b1;
                if (mcnt_reg == fta_pkg::MUL_CNT_W'(1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {
                        {(fta_pkg::OUT_W - fta_pkg::TIME_W - fta_pkg::FRAC_W
                          - fta_pkg::COUNT_W - 1){1'b0}},
                        prod_reg, alpha_reg, dropped_reg, count_reg
                    };
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= fta_pkg::STEP_RESET;
            frame_reg     <= fta_pkg::FRAME_RESET;
            limit_reg     <= fta_pkg::SUBSTEP_RESET;
            bank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            frame_reg     <= frame_next;
            limit_reg     <= limit_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
        end
        count_reg    <= count_next;
        dropped_reg  <= dropped_next;
        alpha_reg    <= alpha_next;
        prod_reg     <= prod_next;
        mbits_reg    <= mbits_next;
        mcnt_reg     <= mcnt_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
